@@ hw/rtl/heightmap_terrain_vertex_macros.svh @@
// Assertion macros shared by the terrain vertex RTL.
`ifndef HEIGHTMAP_TERRAIN_VERTEX_MACROS_SVH
`define HEIGHTMAP_TERRAIN_VERTEX_MACROS_SVH

// Property that must hold at every edge out of reset.
`define HTV_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication.
`define HTV_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/htv_pkg.sv @@
// Types and constants for the terrain vertex block.
`default_nettype none
package htv_pkg;

   localparam int IDX_W  = 10;
   localparam int MAP_W  = 13;
   localparam int SIDE_W = 11;
   localparam int CSR_AW = 2;

   localparam logic [CSR_AW-1:0] CSR_MAP_SIDE   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_GRID_VERTS = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_IMAGE_SIDE = 2'd2;

   localparam logic [MAP_W-1:0]  MAP_SIDE_RST   = 13'd64;
   localparam logic [SIDE_W-1:0] GRID_VERTS_RST = 11'd64;
   localparam logic [SIDE_W-1:0] IMAGE_SIDE_RST = 11'd256;

   localparam logic [20:0] POS_MAX = 21'h1FFFFF;
   localparam logic [18:0] TEX_MAX = 19'h7FFFF;

   localparam int                 HEIGHT_GAIN = 100;
   localparam logic signed [15:0] HEIGHT_BIAS = 16'sd3200;
   localparam logic [29:0]        NY_SQ       = 30'd262144;   // 512 squared

   localparam int DIV_STEPS   = 29;   // quotient bits per divider
   localparam int SQRT_STEPS  = 15;   // root bits
   localparam int FRONT_DEPTH = 5;
   localparam int QDEPTH      = 8;
   localparam int QAW         = 3;
   localparam int BUSY_LEVEL  = QDEPTH - FRONT_DEPTH;

   typedef struct packed {
      logic [9:0]  grid_row;
      logic [9:0]  grid_col;
      logic [23:0] center_pixel;
      logic [23:0] left_pixel;
      logic [23:0] right_pixel;
      logic [23:0] down_pixel;
      logic [23:0] up_pixel;
   } htv_req_type;

   typedef struct packed {
      logic [20:0]        pos_x;
      logic signed [15:0] pos_height;
      logic [20:0]        pos_z;
      logic signed [15:0] normal_x;
      logic [14:0]        normal_y;
      logic signed [15:0] normal_z;
      logic [18:0]        tex_u;
      logic [18:0]        tex_v;
   } htv_rsp_type;

   // Position/texture dividends with their overflow flags.
   typedef struct packed {
      logic [30:0] pos_x_num;
      logic [30:0] pos_z_num;
      logic [28:0] tex_u_num;
      logic [28:0] tex_v_num;
      logic        pos_x_sat;
      logic        pos_z_sat;
      logic        tex_u_sat;
      logic        tex_v_sat;
   } htv_idx_type;

   // One classified vertex between front and back.
   typedef struct packed {
      logic signed [15:0] height;
      logic               neg_x;
      logic               neg_z;
      logic [29:0]        dx2;
      logic [29:0]        dz2;
      logic [30:0]        s;
      htv_idx_type        idx;
   } htv_entry_type;

   typedef struct packed {
      logic           empty;
      logic [QAW:0]   level;
   } htv_qstat_type;

endpackage
`default_nettype wire

@@ hw/rtl/htv_front.sv @@
// Front end: pixel heights, slopes, squared terms and index dividends.
`default_nettype none
module htv_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire htv_pkg::htv_req_type         req,
   input  wire logic [htv_pkg::MAP_W-1:0]    map_side,
   input  wire logic [htv_pkg::SIDE_W-1:0]   vc_cl,
   input  wire logic [htv_pkg::SIDE_W-1:0]   img_cl,
   input  wire logic [htv_pkg::SIDE_W-1:0]   div,
   output logic                              push,
   output htv_pkg::htv_entry_type            push_entry
);

   localparam int PC = 0;
   localparam int PL = 1;
   localparam int PR = 2;
   localparam int PD = 3;
   localparam int PU = 4;

   logic [23:0] pix [5];
   logic [4:0]  in_img;
   logic [10:0] row11, col11;

   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [15:0]        rg1_ff  [5];
   logic [7:0]         b1_ff   [5];
   logic [4:0]         in1_ff, in2_ff;
   logic [22:0]        pmx1_ff, pmz1_ff;
   logic [20:0]        tmu1_ff, tmv1_ff;
   logic [23:0]        rgb2_ff [5];
   htv_pkg::htv_idx_type idx2_ff, idx3_ff, idx4_ff, idx5_ff;
   htv_pkg::htv_idx_type idx2_in;
   logic signed [15:0] h3_ff   [5];
   logic signed [15:0] h3_in   [5];
   logic signed [15:0] dx4_ff, dz4_ff, hc4_ff, hc5_ff;
   logic signed [31:0] sqx, sqz;
   logic [29:0]        dx2_5_ff, dz2_5_ff;
   logic               negx5_ff, negz5_ff;

   assign pix[PC] = req.center_pixel;
   assign pix[PL] = req.left_pixel;
   assign pix[PR] = req.right_pixel;
   assign pix[PD] = req.down_pixel;
   assign pix[PU] = req.up_pixel;

   assign row11 = {1'b0, req.grid_row};
   assign col11 = {1'b0, req.grid_col};

   // neighbor at -1 or past the image edge reads as height zero
   always_comb begin
      in_img[PC] = (row11 < img_cl) && (col11 < img_cl);
      in_img[PL] = (req.grid_row != '0) && (row11 <= img_cl) && (col11 < img_cl);
      in_img[PR] = ({1'b0, row11} + 12'd1 < {1'b0, img_cl}) && (col11 < img_cl);
      in_img[PD] = (req.grid_col != '0) && (col11 <= img_cl) && (row11 < img_cl);
      in_img[PU] = ({1'b0, col11} + 12'd1 < {1'b0, img_cl}) && (row11 < img_cl);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // stage 1: r*g, index products
   always_ff @(posedge clock) begin
      for (int i = 0; i < 5; i++) begin
         rg1_ff[i] <= 16'(pix[i][23:16]) * 16'(pix[i][15:8]);
         b1_ff[i]  <= pix[i][7:0];
      end
      in1_ff  <= in_img;
      pmx1_ff <= 23'(req.grid_col) * 23'(map_side);
      pmz1_ff <= 23'(req.grid_row) * 23'(map_side);
      tmu1_ff <= 21'(req.grid_col) * 21'(vc_cl);
      tmv1_ff <= 21'(req.grid_row) * 21'(vc_cl);
   end

   // stage 2: r*g*b, dividends and overflow checks
   always_comb begin
      idx2_in.pos_x_num = {pmx1_ff, 8'd0};
      idx2_in.pos_z_num = {pmz1_ff, 8'd0};
      idx2_in.tex_u_num = {tmu1_ff, 8'd0};
      idx2_in.tex_v_num = {tmv1_ff, 8'd0};
      idx2_in.pos_x_sat = {1'b0, pmx1_ff[22:13]} >= div;
      idx2_in.pos_z_sat = {1'b0, pmz1_ff[22:13]} >= div;
      idx2_in.tex_u_sat = {1'b0, tmu1_ff[20:11]} >= div;
      idx2_in.tex_v_sat = {1'b0, tmv1_ff[20:11]} >= div;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 5; i++) begin
         rgb2_ff[i] <= 24'(rg1_ff[i]) * 24'(b1_ff[i]);
      end
      in2_ff  <= in1_ff;
      idx2_ff <= idx2_in;
   end

   // stage 3: heights in Q8
   always_comb begin
      logic [30:0] hp;
      hp = '0;
      for (int i = 0; i < 5; i++) begin
         hp = 31'(rgb2_ff[i]) * 31'(htv_pkg::HEIGHT_GAIN);
         h3_in[i] = in2_ff[i] ? ($signed({1'b0, hp[30:16]}) - htv_pkg::HEIGHT_BIAS)
                              : 16'sd0;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 5; i++) begin
         h3_ff[i] <= h3_in[i];
      end
      idx3_ff <= idx2_ff;
   end

   // stage 4: slopes
   always_ff @(posedge clock) begin
      dx4_ff  <= h3_ff[PL] - h3_ff[PR];
      dz4_ff  <= h3_ff[PD] - h3_ff[PU];
      hc4_ff  <= h3_ff[PC];
      idx4_ff <= idx3_ff;
   end

   // stage 5: squares
   assign sqx = dx4_ff * dx4_ff;
   assign sqz = dz4_ff * dz4_ff;

   always_ff @(posedge clock) begin
      dx2_5_ff <= sqx[29:0];
      dz2_5_ff <= sqz[29:0];
      negx5_ff <= dx4_ff[15];
      negz5_ff <= dz4_ff[15];
      hc5_ff   <= hc4_ff;
      idx5_ff  <= idx4_ff;
   end

   always_comb begin
      push             = v5_ff;
      push_entry.height = hc5_ff;
      push_entry.neg_x  = negx5_ff;
      push_entry.neg_z  = negz5_ff;
      push_entry.dx2    = dx2_5_ff;
      push_entry.dz2    = dz2_5_ff;
      push_entry.s      = 31'(dx2_5_ff) + 31'(dz2_5_ff) + 31'(htv_pkg::NY_SQ);
      push_entry.idx    = idx5_ff;
   end

endmodule
`default_nettype wire

@@ hw/rtl/htv_queue.sv @@
// Short FIFO between front and back.
`default_nettype none
module htv_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire htv_pkg::htv_entry_type push_entry,
   input  wire logic                   pop,
   output htv_pkg::htv_entry_type      head,
   output htv_pkg::htv_qstat_type      stat
);

   htv_pkg::htv_entry_type     mem_ff [htv_pkg::QDEPTH];
   logic [htv_pkg::QAW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [htv_pkg::QAW:0]      lvl_ff, lvl_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      lvl_in = lvl_ff + {{htv_pkg::QAW{1'b0}}, push} - {{htv_pkg::QAW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         lvl_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         lvl_ff <= lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   assign head       = mem_ff[rd_ff];
   assign stat.empty = (lvl_ff == '0);
   assign stat.level = lvl_ff;

endmodule
`default_nettype wire

@@ hw/rtl/htv_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module htv_div #(
   parameter int DEN_W = 11
) (
   input  wire logic                                   clock,
   input  wire logic [DEN_W+htv_pkg::DIV_STEPS-1:0]    num,
   input  wire logic [DEN_W-1:0]                       den,
   output logic [htv_pkg::DIV_STEPS-1:0]               quo
);

   localparam int STEPS = htv_pkg::DIV_STEPS;

   // top DEN_W bits of num must be below den
   logic [DEN_W-1:0] rem_s [STEPS];
   logic [STEPS-1:0] sh_s  [STEPS];
   logic [DEN_W-1:0] den_s [STEPS];
   logic [DEN_W-1:0] rem_ff [STEPS-1];
   logic [DEN_W-1:0] den_ff [STEPS-1];
   logic [STEPS-1:0] sh_ff  [STEPS];

   assign rem_s[0] = num[DEN_W+STEPS-1:STEPS];
   assign sh_s[0]  = num[STEPS-1:0];
   assign den_s[0] = den;

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      logic [DEN_W:0]   trial, diff;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      logic [STEPS-1:0] sh_in;

      always_comb begin
         trial  = {rem_s[k], sh_s[k][STEPS-1]};
         diff   = trial - {1'b0, den_s[k]};
         ge     = trial >= {1'b0, den_s[k]};
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         sh_in  = {sh_s[k][STEPS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         sh_ff[k] <= sh_in;
      end

      if (k < STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_s[k];
         end
         assign rem_s[k+1] = rem_ff[k];
         assign den_s[k+1] = den_ff[k];
         assign sh_s[k+1]  = sh_ff[k];
      end
   end

   assign quo = sh_ff[STEPS-1];

endmodule
`default_nettype wire

@@ hw/rtl/htv_back.sv @@
// Back end: divisions, square roots and the output register.
`default_nettype none
module htv_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire htv_pkg::htv_entry_type       head,
   input  wire logic [htv_pkg::SIDE_W-1:0]   div,
   output logic                              rsp_strobe,
   output htv_pkg::htv_rsp_type              rsp_word
);

   localparam int DS = htv_pkg::DIV_STEPS;
   localparam int SS = htv_pkg::SQRT_STEPS;

   typedef struct packed {
      logic signed [15:0] height;
      logic               neg_x;
      logic               neg_z;
      logic               pos_x_sat;
      logic               pos_z_sat;
      logic               tex_u_sat;
      logic               tex_v_sat;
   } side_a_type;

   typedef struct packed {
      logic signed [15:0] height;
      logic               neg_x;
      logic               neg_z;
      logic [20:0]        pos_x;
      logic [20:0]        pos_z;
      logic [18:0]        tex_u;
      logic [18:0]        tex_v;
   } side_b_type;

   logic [DS-1:0] q_nx, q_ny, q_nz, q_px, q_pz, q_tu, q_tv;
   logic [DS-1:0] q_n [3];

   side_a_type a_in;
   side_a_type a_ff [DS];
   logic       va_ff [DS];
   side_b_type b_in;
   side_b_type b_ff [SS];
   logic       vb_ff [SS];

   logic [28:0] sv_s  [3][SS];
   logic [29:0] sr_s  [3][SS];
   logic [28:0] sv_ff [3][SS-1];
   logic [29:0] sr_ff [3][SS];

   logic              strobe_ff;
   htv_pkg::htv_rsp_type word_ff, word_in;

   // normal dividends: d^2 * 2^28 over S
   htv_div #(.DEN_W(31)) u_div_nx (
      .clock (clock),
      .num   (60'({head.dx2, 28'd0})),
      .den   (head.s),
      .quo   (q_nx)
   );
   htv_div #(.DEN_W(31)) u_div_ny (
      .clock (clock),
      .num   (60'({htv_pkg::NY_SQ, 28'd0})),
      .den   (head.s),
      .quo   (q_ny)
   );
   htv_div #(.DEN_W(31)) u_div_nz (
      .clock (clock),
      .num   (60'({head.dz2, 28'd0})),
      .den   (head.s),
      .quo   (q_nz)
   );

   // saturating fields divide zero; their result is forced later
   htv_div #(.DEN_W(htv_pkg::SIDE_W)) u_div_px (
      .clock (clock),
      .num   (40'(head.idx.pos_x_sat ? 31'd0 : head.idx.pos_x_num)),
      .den   (div),
      .quo   (q_px)
   );
   htv_div #(.DEN_W(htv_pkg::SIDE_W)) u_div_pz (
      .clock (clock),
      .num   (40'(head.idx.pos_z_sat ? 31'd0 : head.idx.pos_z_num)),
      .den   (div),
      .quo   (q_pz)
   );
   htv_div #(.DEN_W(htv_pkg::SIDE_W)) u_div_tu (
      .clock (clock),
      .num   (40'(head.idx.tex_u_sat ? 29'd0 : head.idx.tex_u_num)),
      .den   (div),
      .quo   (q_tu)
   );
   htv_div #(.DEN_W(htv_pkg::SIDE_W)) u_div_tv (
      .clock (clock),
      .num   (40'(head.idx.tex_v_sat ? 29'd0 : head.idx.tex_v_num)),
      .den   (div),
      .quo   (q_tv)
   );

   // side data in step with the dividers
   always_comb begin
      a_in.height    = head.height;
      a_in.neg_x     = head.neg_x;
      a_in.neg_z     = head.neg_z;
      a_in.pos_x_sat = head.idx.pos_x_sat;
      a_in.pos_z_sat = head.idx.pos_z_sat;
      a_in.tex_u_sat = head.idx.tex_u_sat;
      a_in.tex_v_sat = head.idx.tex_v_sat;
   end

   always_ff @(posedge clock) begin
      a_ff[0] <= a_in;
      for (int k = 1; k < DS; k++) begin
         a_ff[k] <= a_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DS; k++) begin
            va_ff[k] <= 1'b0;
         end
         for (int k = 0; k < SS; k++) begin
            vb_ff[k] <= 1'b0;
         end
         strobe_ff <= 1'b0;
      end else begin
         va_ff[0] <= in_valid;
         for (int k = 1; k < DS; k++) begin
            va_ff[k] <= va_ff[k-1];
         end
         vb_ff[0] <= va_ff[DS-1];
         for (int k = 1; k < SS; k++) begin
            vb_ff[k] <= vb_ff[k-1];
         end
         strobe_ff <= vb_ff[SS-1];
      end
   end

   // position and texture results, clamped on overflow
   always_comb begin
      b_in.height = a_ff[DS-1].height;
      b_in.neg_x  = a_ff[DS-1].neg_x;
      b_in.neg_z  = a_ff[DS-1].neg_z;
      b_in.pos_x  = a_ff[DS-1].pos_x_sat ? htv_pkg::POS_MAX : q_px[20:0];
      b_in.pos_z  = a_ff[DS-1].pos_z_sat ? htv_pkg::POS_MAX : q_pz[20:0];
      b_in.tex_u  = a_ff[DS-1].tex_u_sat ? htv_pkg::TEX_MAX : q_tu[18:0];
      b_in.tex_v  = a_ff[DS-1].tex_v_sat ? htv_pkg::TEX_MAX : q_tv[18:0];
   end

   always_ff @(posedge clock) begin
      b_ff[0] <= b_in;
      for (int k = 1; k < SS; k++) begin
         b_ff[k] <= b_ff[k-1];
      end
   end

   assign q_n[0] = q_nx;
   assign q_n[1] = q_ny;
   assign q_n[2] = q_nz;

   // bitwise integer square root, two radicand bits per stage
   for (genvar l = 0; l < 3; l++) begin : g_lane
      assign sv_s[l][0] = q_n[l];
      assign sr_s[l][0] = '0;

      for (genvar k = 0; k < SS; k++) begin : g_step
         localparam logic [29:0] BIT = 30'(1) << (28 - 2 * k);
         logic [29:0] trial;
         logic        ge;
         logic [28:0] v_in;
         logic [29:0] r_in;

         always_comb begin
            trial = sr_s[l][k] + BIT;
            ge    = {1'b0, sv_s[l][k]} >= trial;
            v_in  = ge ? sv_s[l][k] - trial[28:0] : sv_s[l][k];
            r_in  = ge ? (sr_s[l][k] >> 1) + BIT : sr_s[l][k] >> 1;
         end

         always_ff @(posedge clock) begin
            sr_ff[l][k] <= r_in;
         end

         if (k < SS - 1) begin : g_carry
            always_ff @(posedge clock) begin
               sv_ff[l][k] <= v_in;
            end
            assign sv_s[l][k+1] = sv_ff[l][k];
            assign sr_s[l][k+1] = sr_ff[l][k];
         end
      end
   end

   always_comb begin
      word_in.pos_x      = b_ff[SS-1].pos_x;
      word_in.pos_height = b_ff[SS-1].height;
      word_in.pos_z      = b_ff[SS-1].pos_z;
      word_in.normal_x   = b_ff[SS-1].neg_x ? 16'sd0 - $signed({1'b0, sr_ff[0][SS-1][14:0]})
                                            : $signed({1'b0, sr_ff[0][SS-1][14:0]});
      word_in.normal_y   = sr_ff[1][SS-1][14:0];
      word_in.normal_z   = b_ff[SS-1].neg_z ? 16'sd0 - $signed({1'b0, sr_ff[2][SS-1][14:0]})
                                            : $signed({1'b0, sr_ff[2][SS-1][14:0]});
      word_in.tex_u      = b_ff[SS-1].tex_u;
      word_in.tex_v      = b_ff[SS-1].tex_v;
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = word_ff;

endmodule
`default_nettype wire

@@ hw/rtl/heightmap_terrain_vertex.sv @@
// Top level of the heightmap terrain vertex generator.
`default_nettype none
`include "heightmap_terrain_vertex_macros.svh"
// Takes one vertex word per clock: grid row/column plus the packed RGB of
// the vertex pixel and its four neighbors. For each word taken on start,
// rsp_strobe is high for one cycle with position, height, unit normal
// (Q1.14) and texture coordinates. A word passes through the front
// (five stages: color products, height, slope, square), one queue slot,
// the 29-stage dividers that form d^2*2^28/S and the index scalings, the
// 15-stage square root, and the output register. Items stream at one per
// cycle with no gaps. The receiver cannot stall; busy only rises if the
// queue between front and back were to back up, which it does not in
// normal streaming. Write CSRs only while no vertex is in flight;
// map_side is used raw, the grid vertex count and image_side clamp at
// MAX_SIDE, and a grid vertex count of 0 or 1 divides by one.
module heightmap_terrain_vertex #(
   parameter int MAX_SIDE = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire htv_pkg::htv_req_type          req_word,
   output logic                               rsp_strobe,
   output htv_pkg::htv_rsp_type               rsp_word,
   input  wire logic                          csr_we,
   input  wire logic [htv_pkg::CSR_AW-1:0]    csr_index,
   input  wire logic [htv_pkg::MAP_W-1:0]     csr_wdata
);

   logic [htv_pkg::MAP_W-1:0]  map_ff;
   logic [htv_pkg::SIDE_W-1:0] vcount_ff, image_ff;
   logic [htv_pkg::SIDE_W-1:0] vc_cl, img_cl, div;
   logic                       accept;
   logic                       push;
   htv_pkg::htv_entry_type     push_entry, head;
   htv_pkg::htv_qstat_type     qstat;

   // CSR bank; out-of-range index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff    <= htv_pkg::MAP_SIDE_RST;
         vcount_ff <= htv_pkg::GRID_VERTS_RST;
         image_ff  <= htv_pkg::IMAGE_SIDE_RST;
      end else if (csr_we) begin
         case (csr_index)
            htv_pkg::CSR_MAP_SIDE:   map_ff    <= csr_wdata;
            htv_pkg::CSR_GRID_VERTS: vcount_ff <= csr_wdata[htv_pkg::SIDE_W-1:0];
            htv_pkg::CSR_IMAGE_SIDE: image_ff  <= csr_wdata[htv_pkg::SIDE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // clamp to MAX_SIDE; grid divisor is count-1, at least one
   always_comb begin
      vc_cl  = ({2'b0, vcount_ff} > 13'(MAX_SIDE)) ? htv_pkg::SIDE_W'(MAX_SIDE) : vcount_ff;
      img_cl = ({2'b0, image_ff} > 13'(MAX_SIDE))  ? htv_pkg::SIDE_W'(MAX_SIDE) : image_ff;
      div    = (vc_cl > 11'd1) ? vc_cl - 11'd1 : 11'd1;
   end

   assign busy   = (qstat.level >= (htv_pkg::QAW+1)'(htv_pkg::BUSY_LEVEL));
   assign accept = start && !busy;

   htv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_word),
      .map_side   (map_ff),
      .vc_cl      (vc_cl),
      .img_cl     (img_cl),
      .div        (div),
      .push       (push),
      .push_entry (push_entry)
   );

   htv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (!qstat.empty),
      .head       (head),
      .stat       (qstat)
   );

   htv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (!qstat.empty),
      .head       (head),
      .div        (div),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // queue never runs past its depth
   `HTV_ASSERT_ALWAYS(a_queue_bound, qstat.level <= (htv_pkg::QAW+1)'(htv_pkg::QDEPTH), "queue overrun")
   // normal always keeps a positive vertical part
   `HTV_ASSERT_IMPLIES(a_normal_y_pos, rsp_strobe, rsp_word.normal_y != '0, "normal_y zero")
   // height never drops below the bias floor
   `HTV_ASSERT_IMPLIES(a_height_floor, rsp_strobe, rsp_word.pos_height >= -htv_pkg::HEIGHT_BIAS, "height low")

endmodule
`default_nettype wire

@@ sim/heightmap_terrain_vertex_tb.sv @@
// Testbench for the terrain vertex generator: self-checking against a built-in predictor.
`timescale 1ns / 1ps
module heightmap_terrain_vertex_tb;

   // Index past the last register; writes to it must be ignored.
   localparam logic [htv_pkg::CSR_AW-1:0] CSR_SPARE = 2'd3;
   localparam int SIDE_CLAMP = 1024;
   localparam int DRAIN_CYCLES = 60;   // a bit more than the pipeline latency

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   htv_pkg::htv_req_type       req_word;
   logic                       rsp_strobe;
   htv_pkg::htv_rsp_type       rsp_word;
   logic                       csr_we;
   logic [htv_pkg::CSR_AW-1:0] csr_index;
   logic [htv_pkg::MAP_W-1:0]  csr_wdata;

   // Shadow copy of the registers.
   logic [12:0] map_side_q;
   logic [10:0] grid_verts_q;
   logic [10:0] image_side_q;

   htv_pkg::htv_rsp_type vertex_queue[$];
   int          mismatch_count;
   int          idle_pct;

   heightmap_terrain_vertex dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------- predictor ----------------

   // Q8 height of one pixel, zero outside the clamped square image.
   function automatic int pixel_q8(int x, int z, logic [23:0] pix);
      int side;
      longint unsigned prod;
      begin
         side = (image_side_q > SIDE_CLAMP) ? SIDE_CLAMP : int'(image_side_q);
         if (x < 0 || x >= side || z < 0 || z >= side)
            return 0;
         prod = longint'(pix[23:16]) * pix[15:8] * pix[7:0] * 100;
         return int'(prod >> 16) - 3200;
      end
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      begin
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > v)
            bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= root + bitv) begin
               v = v - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         return root;
      end
   endfunction

   // |d|*16384/sqrt(s), truncated, sign of d.
   function automatic int unit_part(int d, longint unsigned s);
      longint unsigned mag;
      int q;
      begin
         mag = (d < 0) ? longint'(-d) : longint'(d);
         q = int'(int_sqrt(((mag * mag) << 28) / s));
         return (d < 0) ? -q : q;
      end
   endfunction

   function automatic longint unsigned scale_index(longint unsigned idx, longint unsigned mul,
                                                   longint unsigned dv, longint unsigned lim);
      longint unsigned v;
      begin
         v = idx * mul * 256 / dv;
         return (v > lim) ? lim : v;
      end
   endfunction

   function automatic htv_pkg::htv_rsp_type vertex_expected(htv_pkg::htv_req_type w);
      htv_pkg::htv_rsp_type r;
      int row, col, hc, dx, dz;
      longint unsigned s, dv, vc;
      begin
         row = int'(w.grid_row);
         col = int'(w.grid_col);
         hc = pixel_q8(row, col, w.center_pixel);
         dx = pixel_q8(row - 1, col, w.left_pixel) - pixel_q8(row + 1, col, w.right_pixel);
         dz = pixel_q8(row, col - 1, w.down_pixel) - pixel_q8(row, col + 1, w.up_pixel);
         s = longint'(dx) * dx + 262144 + longint'(dz) * dz;
         vc = (grid_verts_q > SIDE_CLAMP) ? SIDE_CLAMP : grid_verts_q;
         dv = (vc > 1) ? vc - 1 : 1;
         r.pos_x      = 21'(scale_index(col, map_side_q, dv, htv_pkg::POS_MAX));
         r.pos_height = 16'(hc);
         r.pos_z      = 21'(scale_index(row, map_side_q, dv, htv_pkg::POS_MAX));
         r.normal_x   = 16'(unit_part(dx, s));
         r.normal_y   = 15'(unit_part(512, s));
         r.normal_z   = 16'(unit_part(dz, s));
         r.tex_u      = 19'(scale_index(col, vc, dv, htv_pkg::TEX_MAX));
         r.tex_v      = 19'(scale_index(row, vc, dv, htv_pkg::TEX_MAX));
         return r;
      end
   endfunction

   // ---------------- checking ----------------

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      begin
         $display("%0t: %s got %h want %h", $realtime, field, got, want);
         mismatch_count++;
      end
   endtask

   task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch(field, got, want);
   endtask

   always @(posedge clock) begin
      htv_pkg::htv_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (vertex_queue.size() == 0) begin
            report_mismatch("unexpected word", 32'(rsp_word.pos_x), 32'd0);
         end else begin
            want = vertex_queue.pop_front();
            check_field("pos_x", 32'(rsp_word.pos_x), 32'(want.pos_x));
            check_field("pos_height", 32'(unsigned'(rsp_word.pos_height)),
                        32'(unsigned'(want.pos_height)));
            check_field("pos_z", 32'(rsp_word.pos_z), 32'(want.pos_z));
            check_field("normal_x", 32'(unsigned'(rsp_word.normal_x)),
                        32'(unsigned'(want.normal_x)));
            check_field("normal_y", 32'(rsp_word.normal_y), 32'(want.normal_y));
            check_field("normal_z", 32'(unsigned'(rsp_word.normal_z)),
                        32'(unsigned'(want.normal_z)));
            check_field("tex_u", 32'(rsp_word.tex_u), 32'(want.tex_u));
            check_field("tex_v", 32'(rsp_word.tex_v), 32'(want.tex_v));
         end
      end
   end

   // ---------------- stimulus helpers ----------------

   // Send one word; start stays high between back-to-back words.
   task automatic send_vertex(htv_pkg::htv_req_type w);
      int gap;
      begin
         gap = 0;
         while ($urandom_range(99) < idle_pct && gap < 40)
            gap++;
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         start <= 1'b1;
         req_word <= w;
         do @(posedge clock); while (busy);
         vertex_queue.push_back(vertex_expected(w));
      end
   endtask

   task automatic drain_pipe;
      begin
         start <= 1'b0;
         @(posedge clock);
         while (vertex_queue.size() != 0)
            @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [htv_pkg::CSR_AW-1:0] idx, logic [htv_pkg::MAP_W-1:0] data);
      begin
         csr_we <= 1'b1;
         csr_index <= idx;
         csr_wdata <= data;
         @(posedge clock);
      end
   endtask

   // Block idle on entry. Raw 13-bit data; grid count and image side keep only 11 bits.
   task automatic load_setting(logic [12:0] ms, logic [12:0] vc, logic [12:0] img);
      begin
         csr_write(htv_pkg::CSR_MAP_SIDE, ms);
         csr_write(htv_pkg::CSR_GRID_VERTS, vc);
         csr_write(htv_pkg::CSR_IMAGE_SIDE, img);
         csr_write(CSR_SPARE, 13'($urandom));
         csr_we <= 1'b0;
         map_side_q = ms;
         grid_verts_q = vc[10:0];
         image_side_q = img[10:0];
      end
   endtask

   function automatic htv_pkg::htv_req_type make_vertex(int row, int col, logic [23:0] c,
                                                        logic [23:0] l, logic [23:0] r,
                                                        logic [23:0] d, logic [23:0] u);
      htv_pkg::htv_req_type w;
      begin
         w.grid_row = 10'(row);
         w.grid_col = 10'(col);
         w.center_pixel = c;
         w.left_pixel = l;
         w.right_pixel = r;
         w.down_pixel = d;
         w.up_pixel = u;
         return w;
      end
   endfunction

   function automatic logic [23:0] rand_pixel;
      case ($urandom_range(7))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   // Row/col often placed on the image border so neighbors fall outside.
   function automatic int rand_index;
      int side;
      begin
         side = (image_side_q > SIDE_CLAMP) ? SIDE_CLAMP : int'(image_side_q);
         case ($urandom_range(3))
            0: return $urandom_range(1) ? 0 : 1023;
            1: return (side + $urandom_range(2) - 1 + 1024) % 1024;
            default: return $urandom_range(1023);
         endcase
      end
   endfunction

   // ---------------- tests ----------------

   // Reset values, then field extremes and border cases.
   task automatic test_directed;
      begin
         idle_pct = 0;
         send_vertex(make_vertex(0, 0, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
                                 24'h000000));
         send_vertex(make_vertex(5, 7, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                 24'hFFFFFF));
         // steep slopes, both signs
         send_vertex(make_vertex(10, 10, 24'h808080, 24'hFFFFFF, 24'h000000, 24'h000000,
                                 24'hFFFFFF));
         send_vertex(make_vertex(10, 10, 24'h808080, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
                                 24'h000000));
         // image border: neighbors at -1 and at image_side
         send_vertex(make_vertex(0, 255, 24'h123456, 24'hFFFFFF, 24'hABCDEF, 24'h777777,
                                 24'hFFFFFF));
         send_vertex(make_vertex(255, 0, 24'h654321, 24'h999999, 24'hFFFFFF, 24'hFFFFFF,
                                 24'h3C3C3C));
         send_vertex(make_vertex(256, 256, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                 24'hFFFFFF));
         send_vertex(make_vertex(1023, 1023, 24'hFF00FF, 24'h00FF00, 24'hAAAAAA, 24'h555555,
                                 24'hFFFFFF));
         send_vertex(make_vertex(682, 341, 24'hA5A5A5, 24'h5A5A5A, 24'h0F0F0F, 24'hF0F0F0,
                                 24'h010203));
         // hold off until every word has come back
         drain_pipe();
         // largest scale, smallest grid: positions saturate
         load_setting(13'd8191, 13'd2, 13'd1024);
         send_vertex(make_vertex(1023, 1, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
                                 24'h000000));
         send_vertex(make_vertex(1, 1023, 24'h010101, 24'hFFFFFF, 24'h000000, 24'h000000,
                                 24'hFFFFFF));
         drain_pipe();
         // degenerate grid and empty image
         load_setting(13'd0, 13'd1, 13'd0);
         send_vertex(make_vertex(3, 4, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                                 24'h000000));
         drain_pipe();
         load_setting(13'd1, 13'd0, 13'd1);
         send_vertex(make_vertex(0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                 24'hFFFFFF));
         send_vertex(make_vertex(1, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                 24'hFFFFFF));
         drain_pipe();
         // oversized sides clamp; upper data bits dropped
         load_setting(13'd4096, 13'h1FFF, 13'h1FFF);
         send_vertex(make_vertex(1023, 1023, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000,
                                 24'hFFFFFF));
         send_vertex(make_vertex(1022, 0, 24'h808080, 24'h000000, 24'hFFFFFF, 24'h101010,
                                 24'hEEEEEE));
         drain_pipe();
      end
   endtask

   // Random words over a series of settings and idle patterns.
   task automatic test_random_sweep;
      int pct[4];
      logic [12:0] ms, vc, img;
      begin
         pct = '{0, 84, 35, 0};
         for (int ph = 0; ph < 8; ph++) begin
            case (ph)
               0: begin ms = 13'd64;   vc = 13'd64;   img = 13'd256;  end
               1: begin ms = 13'd1;    vc = 13'd1024; img = 13'd1024; end
               2: begin ms = 13'd4096; vc = 13'd2;    img = 13'd1;    end
               3: begin ms = 13'd8191; vc = 13'd1025; img = 13'd2047; end
               4: begin ms = 13'd0;    vc = 13'd0;    img = 13'd0;    end
               default: begin
                  ms = 13'($urandom);
                  vc = 13'($urandom_range(1030));
                  img = 13'($urandom_range(1030));
               end
            endcase
            load_setting(ms, vc, img);
            idle_pct = pct[ph % 4];
            for (int n = 0; n < 175; n++) begin
               // no idling for a stretch in every phase
               if (n == 120)
                  idle_pct = 0;
               send_vertex(make_vertex(rand_index(), rand_index(), rand_pixel(), rand_pixel(),
                                       rand_pixel(), rand_pixel(), rand_pixel()));
            end
            drain_pipe();
         end
      end
   endtask

   initial begin
      mismatch_count = 0;
      idle_pct = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_word <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      map_side_q = htv_pkg::MAP_SIDE_RST;
      grid_verts_q = htv_pkg::GRID_VERTS_RST;
      image_side_q = htv_pkg::IMAGE_SIDE_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_sweep();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
